/* rtl/skt_pkg.sv */
package skt_pkg;

   // Default table geometry.
   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int KEY_BITS_DEFAULT    = 16;

   // Widths of the word fields.
   localparam int INDEX_BITS  = 16;
   localparam int STATUS_BITS = 2;
   localparam int SLOT_BITS   = 6;
   localparam int COUNT_BITS  = 7;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] ST_FOUND   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_ADDED   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd3;

   // Request word.
   typedef struct packed {
      logic                  operation;
      logic                  table_select;
      logic [INDEX_BITS-1:0] reg_key;
   } req_word_type;

   // Response word.
   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [SLOT_BITS-1:0]   slot_position;
      logic [COUNT_BITS-1:0]  entry_count;
   } rsp_word_type;

endpackage

/* rtl/skt_cell.sv */
module skt_cell #(
   parameter int KEY_BITS = skt_pkg::KEY_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic [KEY_BITS-1:0] cmp_key,
   input  logic                cmp_view,
   input  logic                occupied,
   input  logic                commit,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic                left_lt,
   output logic [KEY_BITS-1:0] own_key,
   output logic                lt_ff,
   output logic                eq_ff,
   output logic                boundary
);

   logic [KEY_BITS-1:0] res_key_ff;
   logic [KEY_BITS-1:0] view_key_ff;
   logic [KEY_BITS-1:0] new_key;
   logic                lt_in;
   logic                eq_in;

   // The key of the selected table is the one compared and handed to the right neighbor.
   assign own_key = cmp_view ? view_key_ff : res_key_ff;

   // Compare the held key with the request key.
   assign lt_in = occupied && (own_key < cmp_key);
   assign eq_in = occupied && (own_key == cmp_key);

   // The insert slot is the first cell whose key is not below the request key.
   assign boundary = left_lt && !lt_ff;

   // The boundary cell takes the new key; cells above it take their left neighbor's key.
   assign new_key = left_lt ? cmp_key : left_key;

   always_ff @(posedge clock) begin
      lt_ff <= lt_in;
      eq_ff <= eq_in;
      if (commit && !lt_ff) begin
         if (cmp_view) begin
            view_key_ff <= new_key;
         end else begin
            res_key_ff <= new_key;
         end
      end
   end

endmodule

/* rtl/sorted_key_table_find_or_insert.sv */
// A request word passes the compare state, which registers the compare pass over the cell
// row, and the commit state, which decides and shifts the row and registers the response;
// a stalled response holds the commit. A new request can be accepted while the last commits.
// Reset clears both fill counts and the control state; table keys are not
// cleared and only slots below the fill count are ever read.
module sorted_key_table_find_or_insert #(
   parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEFAULT,
   parameter int KEY_BITS    = skt_pkg::KEY_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  skt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output skt_pkg::rsp_word_type rsp_word
);

   import skt_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_COMMIT
   } state_type;

   state_type           state_ff;
   logic                op_ff;
   logic                view_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [CW-1:0]       res_fill_ff;
   logic [CW-1:0]       view_fill_ff;
   logic                rsp_valid_ff;
   rsp_word_type        rsp_word_ff;

   logic                accept;
   logic                can_commit;
   logic                commit_now;
   logic                do_insert;
   logic                found;
   logic                full;
   logic [CW-1:0]       fill_sel;
   logic [CW-1:0]       fill_in;
   logic [IW-1:0]       pos_enc;
   rsp_word_type        rsp_word_in;

   logic [KEY_BITS-1:0]    cell_key [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_lt;
   logic [TABLE_DEPTH-1:0] cell_eq;
   logic [TABLE_DEPTH-1:0] cell_bnd;

   // Handshake control.
   assign can_commit = !rsp_valid_ff || !rsp_stall;
   assign commit_now = (state_ff == S_COMMIT) && can_commit;
   assign req_stall  = (state_ff == S_COMPARE) || ((state_ff == S_COMMIT) && !can_commit);
   assign accept     = req_valid && !req_stall;

   assign fill_sel = view_ff ? view_fill_ff : res_fill_ff;

   // Row of cells; each cell takes the key of its left neighbor on a shift.
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic [KEY_BITS-1:0] left_key;
      logic                left_lt;
      if (g == 0) begin : g_first
         assign left_key = key_ff;
         assign left_lt  = 1'b1;
      end else begin : g_rest
         assign left_key = cell_key[g-1];
         assign left_lt  = cell_lt[g-1];
      end
      skt_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock    (clock),
         .cmp_key  (key_ff),
         .cmp_view (view_ff),
         .occupied (fill_sel > CW'(g)),
         .commit   (do_insert),
         .left_key (left_key),
         .left_lt  (left_lt),
         .own_key  (cell_key[g]),
         .lt_ff    (cell_lt[g]),
         .eq_ff    (cell_eq[g]),
         .boundary (cell_bnd[g])
      );
   end

   // Encode the one-hot boundary flag into a slot number.
   always_comb begin
      pos_enc = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (cell_bnd[i]) begin
            pos_enc = pos_enc | IW'(i);
         end
      end
   end

   // Decide the outcome from the registered cell flags.
   assign found     = |cell_eq;
   assign full      = (fill_sel == CW'(TABLE_DEPTH));
   assign do_insert = commit_now && !found && op_ff && !full;
   assign fill_in   = fill_sel + CW'(do_insert);

   always_comb begin
      rsp_word_in.entry_count = COUNT_BITS'(fill_sel + CW'(!found && op_ff && !full));
      priority if (found) begin
         rsp_word_in.status        = ST_FOUND;
         rsp_word_in.slot_position = SLOT_BITS'(pos_enc);
      end else if (!op_ff) begin
         rsp_word_in.status        = ST_MISSING;
         rsp_word_in.slot_position = '0;
      end else if (full) begin
         rsp_word_in.status        = ST_FULL;
         rsp_word_in.slot_position = '0;
      end else begin
         rsp_word_in.status        = ST_ADDED;
         rsp_word_in.slot_position = SLOT_BITS'(pos_enc);
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_word.operation;
         view_ff <= req_word.table_select;
         key_ff  <= KEY_BITS'(req_word.reg_key);
      end
   end

   // Sequencer, fill counts and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_fill_ff  <= '0;
         view_fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A commit sets the response valid; a stalled response stays valid.
         rsp_valid_ff <= commit_now || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_COMPARE;
               end
            end
            S_COMPARE: begin
               state_ff <= S_COMMIT;
            end
            S_COMMIT: begin
               if (can_commit) begin
                  rsp_word_ff <= rsp_word_in;
                  if (view_ff) begin
                     view_fill_ff <= fill_in;
                  end else begin
                     res_fill_ff <= fill_in;
                  end
                  state_ff <= accept ? S_COMPARE : S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
